### sv/bfie_pkg.sv
// ----------------------------------------------------------------------------
// bfie_pkg
// Types and opcode constants shared by the instruction executor.
// ----------------------------------------------------------------------------
package bfie_pkg;

	localparam int PROG_ADDR_W = 12;
	localparam int ARG_W       = 16;
	localparam int OPC_W       = 4;
	localparam int LEN_W       = 13;

	localparam logic [OPC_W-1:0] OPC_INC    = 4'd0;
	localparam logic [OPC_W-1:0] OPC_DEC    = 4'd1;
	localparam logic [OPC_W-1:0] OPC_NEXT   = 4'd2;
	localparam logic [OPC_W-1:0] OPC_PREV   = 4'd3;
	localparam logic [OPC_W-1:0] OPC_JSTART = 4'd4;
	localparam logic [OPC_W-1:0] OPC_JBACK  = 4'd5;
	localparam logic [OPC_W-1:0] OPC_IN     = 4'd6;
	localparam logic [OPC_W-1:0] OPC_OUT    = 4'd7;
	localparam logic [OPC_W-1:0] OPC_ADD    = 4'd8;
	localparam logic [OPC_W-1:0] OPC_MOVE   = 4'd9;
	localparam logic [OPC_W-1:0] OPC_JUMP   = 4'd10;
	localparam logic [OPC_W-1:0] OPC_CLR    = 4'd11;
	localparam logic [OPC_W-1:0] OPC_ADDCLR = 4'd12;
	localparam logic [OPC_W-1:0] OPC_MOVNZ  = 4'd13;
	localparam logic [OPC_W-1:0] OPC_END    = 4'd14;

	localparam logic ITEM_LOAD = 1'b0;

	typedef struct packed {
		logic                    op;
		logic [PROG_ADDR_W-1:0]  prog_addr;
		logic [OPC_W-1:0]        prog_opcode;
		logic signed [ARG_W-1:0] prog_arg;
		logic [7:0]              in_byte;
		logic                    in_present;
	} item_t;

	typedef struct packed {
		logic                   out_valid;
		logic [7:0]             out_byte;
		logic                   input_used;
		logic [PROG_ADDR_W-1:0] next_pc;
		logic                   is_running;
		logic                   fault;
	} result_t;

	typedef struct packed {
		logic [OPC_W-1:0] opcode;
		logic [ARG_W-1:0] arg;
	} prog_word_t;

endpackage

### sv/brainfuck_instruction_executor_top.sv
// ----------------------------------------------------------------------------
// brainfuck_instruction_executor_top
// Program store and tape executor with fused operations and bracket scans.
// ----------------------------------------------------------------------------
// One item is in flight at a time. A load or a stopped execute is answered
// from idle; a plain instruction reads program and tape, then executes and
// writes back; ADDCLR adds the current cell into the target and zeroes it.
// A bracket scan reads, then checks each program word walked, and MOVNZ
// reads one tape cell per step, both paced by the single read port of the
// memory concerned. After reset the tape is cleared one cell a cycle, and
// no item is taken meanwhile. Both depths must be powers of two.
module brainfuck_instruction_executor_top #(
	parameter int PROGRAM_DEPTH = 4096,
	parameter int TAPE_DEPTH    = 4096
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [bfie_pkg::LEN_W-1:0]            cfg_data,
	input  logic                                  item_valid,
	output logic                                  item_ready,
	input  bfie_pkg::item_t                       item,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output bfie_pkg::result_t                     result
);

	localparam int PAW = $clog2(PROGRAM_DEPTH);
	localparam int TAW = $clog2(TAPE_DEPTH);
	localparam int JW  = PAW + 1;
	localparam int NW  = PAW + 2;
	localparam int CW  = 18;

	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_EXEC, S_SCAN_RD, S_SCAN_EX,
		S_ADDCLR_WR, S_ADDCLR_CLR, S_MOVNZ
	} state_t;

	state_t state_q;

	bfie_pkg::prog_word_t prog_mem [PROGRAM_DEPTH];
	logic [7:0]           tape_mem [TAPE_DEPTH];
	bfie_pkg::prog_word_t prog_rd;
	logic [7:0]           tape_rd;
	logic [PAW-1:0]       prog_ra;
	logic [TAW-1:0]       tape_ra, tape_wa;
	logic [7:0]           tape_wd;
	logic                 tape_we;

	logic [bfie_pkg::LEN_W-1:0] len_q;
	logic [PAW-1:0]             pc_q;
	logic [TAW-1:0]             ptr_q, p_q;
	logic                       run_q, fault_q;
	logic                       outv_q, inused_q, res_valid_q;
	logic [7:0]                 outb_q, cell_q;
	logic [bfie_pkg::ARG_W-1:0] arg_q;
	logic [JW-1:0]              j_q;
	logic [NW-1:0]              nest_q;
	logic                       fwd_q;
	logic [TAW:0]               cnt_q;
	logic [7:0]                 item_in_byte_q;
	logic                       item_in_present_q;

	logic                       accept;
	logic [bfie_pkg::ARG_W-1:0] arg_e;
	logic [CW-1:0]              lim;
	logic [NW-1:0]              nest_n;
	logic [PAW-1:0]             pc_inc, pc_jmp;
	logic                       arg_pos;

	assign cfg_ready    = 1'b1;
	assign item_ready   = (state_q == S_IDLE) && (!res_valid_q || result_ready);
	assign accept       = item_valid && item_ready;
	assign result_valid = res_valid_q;

	assign result.out_valid  = outv_q;
	assign result.out_byte   = outb_q;
	assign result.input_used = inused_q;
	assign result.next_pc    = bfie_pkg::PROG_ADDR_W'(pc_q);
	assign result.is_running = run_q;
	assign result.fault      = fault_q;

	assign arg_e   = prog_rd.arg;
	assign lim     = (CW'(len_q) < CW'(PROGRAM_DEPTH)) ? CW'(len_q) : CW'(PROGRAM_DEPTH);
	assign pc_inc  = pc_q + PAW'(1);
	assign arg_pos = !arg_e[bfie_pkg::ARG_W-1] && (arg_e != '0);
	assign pc_jmp  = pc_q + PAW'(arg_e);

	always_comb begin
		nest_n = nest_q;
		if (prog_rd.opcode == bfie_pkg::OPC_JSTART) begin
			nest_n = fwd_q ? nest_q + NW'(1) : nest_q - NW'(1);
		end else if (prog_rd.opcode == bfie_pkg::OPC_JBACK) begin
			nest_n = fwd_q ? nest_q - NW'(1) : nest_q + NW'(1);
		end
	end

	always_comb begin
		prog_ra = (state_q == S_SCAN_RD) ? j_q[PAW-1:0] : pc_q;
		unique case (state_q)
			S_EXEC:  tape_ra = ptr_q + TAW'(arg_e);
			S_MOVNZ: tape_ra = p_q + TAW'(arg_q);
			default: tape_ra = ptr_q;
		endcase
		tape_we = 1'b0;
		tape_wa = ptr_q;
		tape_wd = 8'd0;
		unique case (state_q)
			S_CLEAR: begin
				tape_we = !cnt_q[TAW];
				tape_wa = cnt_q[TAW-1:0];
			end
			S_EXEC: begin
				unique case (prog_rd.opcode)
					bfie_pkg::OPC_INC: begin
						tape_we = 1'b1;
						tape_wd = tape_rd + 8'd1;
					end
					bfie_pkg::OPC_DEC: begin
						tape_we = 1'b1;
						tape_wd = tape_rd - 8'd1;
					end
					bfie_pkg::OPC_ADD: begin
						tape_we = 1'b1;
						tape_wd = tape_rd + arg_e[7:0];
					end
					bfie_pkg::OPC_IN: begin
						tape_we = 1'b1;
						tape_wd = item_in_present_q ? item_in_byte_q : 8'd0;
					end
					bfie_pkg::OPC_CLR: tape_we = 1'b1;
					default: tape_we = 1'b0;
				endcase
			end
			S_ADDCLR_WR: begin
				tape_we = 1'b1;
				tape_wa = p_q;
				tape_wd = tape_rd + cell_q;
			end
			S_ADDCLR_CLR: tape_we = 1'b1;
			default: tape_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && item.op == bfie_pkg::ITEM_LOAD) begin
			prog_mem[PAW'(item.prog_addr)] <= {item.prog_opcode, item.prog_arg};
		end
		prog_rd <= prog_mem[prog_ra];
	end

	always_ff @(posedge clk) begin
		if (tape_we) begin
			tape_mem[tape_wa] <= tape_wd;
		end
		tape_rd <= tape_mem[tape_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cnt_q       <= '0;
			len_q       <= '0;
			pc_q        <= '0;
			ptr_q       <= '0;
			run_q       <= 1'b1;
			fault_q     <= 1'b0;
			res_valid_q <= 1'b0;
			outv_q      <= 1'b0;
			outb_q      <= 8'd0;
			inused_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				len_q <= cfg_data;
			end
			if (res_valid_q && result_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					cnt_q <= cnt_q + (TAW+1)'(1);
					if (cnt_q[TAW]) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						outv_q            <= 1'b0;
						outb_q            <= 8'd0;
						inused_q          <= 1'b0;
						item_in_byte_q    <= item.in_byte;
						item_in_present_q <= item.in_present;
						if (item.op == bfie_pkg::ITEM_LOAD || !run_q) begin
							res_valid_q <= 1'b1;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_EXEC: begin
					cell_q  <= tape_rd;
					arg_q   <= arg_e;
					state_q <= S_IDLE;
					res_valid_q <= 1'b1;
					unique case (prog_rd.opcode)
						bfie_pkg::OPC_INC, bfie_pkg::OPC_DEC, bfie_pkg::OPC_ADD,
						bfie_pkg::OPC_CLR: pc_q <= pc_inc;
						bfie_pkg::OPC_NEXT: begin
							ptr_q <= ptr_q + TAW'(1);
							pc_q  <= pc_inc;
						end
						bfie_pkg::OPC_PREV: begin
							ptr_q <= ptr_q - TAW'(1);
							pc_q  <= pc_inc;
						end
						bfie_pkg::OPC_MOVE: begin
							ptr_q <= ptr_q + TAW'(arg_e);
							pc_q  <= pc_inc;
						end
						bfie_pkg::OPC_IN: begin
							inused_q <= 1'b1;
							pc_q     <= pc_inc;
						end
						bfie_pkg::OPC_OUT: begin
							outv_q <= 1'b1;
							outb_q <= tape_rd;
							pc_q   <= pc_inc;
						end
						bfie_pkg::OPC_JUMP: begin
							if (arg_pos) begin
								pc_q <= (tape_rd == 8'd0) ? pc_jmp : pc_inc;
							end else begin
								pc_q <= (tape_rd != 8'd0) ? pc_jmp : pc_inc;
							end
						end
						bfie_pkg::OPC_END: run_q <= 1'b0;
						bfie_pkg::OPC_JSTART: begin
							if (tape_rd == 8'd0) begin
								res_valid_q <= 1'b0;
								fwd_q       <= 1'b1;
								j_q         <= JW'(pc_q) + JW'(1);
								nest_q      <= NW'(1);
								state_q     <= S_SCAN_RD;
							end else begin
								pc_q <= pc_inc;
							end
						end
						bfie_pkg::OPC_JBACK: begin
							if (tape_rd == 8'd0) begin
								pc_q <= pc_inc;
							end else if (pc_q != '0 && CW'(pc_q - PAW'(1)) < lim) begin
								res_valid_q <= 1'b0;
								fwd_q       <= 1'b0;
								j_q         <= JW'(pc_q - PAW'(1));
								nest_q      <= NW'(1);
								state_q     <= S_SCAN_RD;
							end else begin
								fault_q <= 1'b1;
								run_q   <= 1'b0;
							end
						end
						bfie_pkg::OPC_ADDCLR: begin
							res_valid_q <= 1'b0;
							p_q         <= ptr_q + TAW'(arg_e);
							state_q     <= S_ADDCLR_WR;
						end
						bfie_pkg::OPC_MOVNZ: begin
							if (tape_rd == 8'd0) begin
								pc_q <= pc_inc;
							end else begin
								res_valid_q <= 1'b0;
								p_q         <= ptr_q + TAW'(arg_e);
								cnt_q       <= (TAW+1)'(1);
								state_q     <= S_MOVNZ;
							end
						end
						default: pc_q <= pc_q;
					endcase
				end
				S_SCAN_RD: begin
					if (fwd_q && !(CW'(j_q) < lim)) begin
						fault_q     <= 1'b1;
						run_q       <= 1'b0;
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						state_q <= S_SCAN_EX;
					end
				end
				S_SCAN_EX: begin
					nest_q <= nest_n;
					if (nest_n == '0) begin
						pc_q        <= j_q[PAW-1:0];
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else if (!fwd_q && j_q == '0) begin
						fault_q     <= 1'b1;
						run_q       <= 1'b0;
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						j_q     <= fwd_q ? j_q + JW'(1) : j_q - JW'(1);
						state_q <= S_SCAN_RD;
					end
				end
				S_ADDCLR_WR: state_q <= S_ADDCLR_CLR;
				S_ADDCLR_CLR: begin
					pc_q        <= pc_inc;
					res_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_MOVNZ: begin
					if (tape_rd == 8'd0) begin
						ptr_q       <= p_q;
						pc_q        <= pc_inc;
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else if (cnt_q == (TAW+1)'(TAPE_DEPTH)) begin
						fault_q     <= 1'b1;
						run_q       <= 1'b0;
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else begin
						p_q   <= p_q + TAW'(arg_q);
						cnt_q <= cnt_q + (TAW+1)'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### tb/sv/bfie_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfie_checker
// Tracks the executor's program store, tape and registers from the observed
// transfers, works out the result of every accepted item and compares each
// returned result with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module bfie_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [bfie_pkg::LEN_W-1:0]   cfg_data,
	input  logic                         item_valid,
	input  logic                         item_ready,
	input  bfie_pkg::item_t              item,
	input  logic                         result_valid,
	input  logic                         result_ready,
	input  bfie_pkg::result_t            result,
	output int                           errors,
	output int                           pending
);

	bfie_pkg::prog_word_t       prog_mem [4096];
	logic [7:0]                 tape_mem [4096];
	logic [11:0]                pc_q;
	logic [11:0]                ptr_q;
	logic                       run_q;
	logic                       fault_q;
	logic [bfie_pkg::LEN_W-1:0] prog_len;
	bfie_pkg::result_t          expected_q [$];

	task automatic step_executor(input bfie_pkg::item_t it, output bfie_pkg::result_t r);
		bfie_pkg::prog_word_t w;
		logic [7:0] cell_v;
		logic [11:0] t;
		logic [11:0] p;
		int lim;
		int j;
		int nest;
		int n;
		int tgt;
		bit found;
		r = '0;
		if (it.op == bfie_pkg::ITEM_LOAD) begin
			prog_mem[it.prog_addr] = {it.prog_opcode, it.prog_arg};
		end else if (run_q) begin
			w = prog_mem[pc_q];
			cell_v = tape_mem[ptr_q];
			lim = (prog_len < 4096) ? int'(prog_len) : 4096;
			found = 1'b0;
			tgt = 0;
			nest = 1;
			case (w.opcode)
				bfie_pkg::OPC_INC: begin
					tape_mem[ptr_q] = cell_v + 8'd1;
					pc_q++;
				end
				bfie_pkg::OPC_DEC: begin
					tape_mem[ptr_q] = cell_v - 8'd1;
					pc_q++;
				end
				bfie_pkg::OPC_NEXT: begin
					ptr_q++;
					pc_q++;
				end
				bfie_pkg::OPC_PREV: begin
					ptr_q--;
					pc_q++;
				end
				bfie_pkg::OPC_JSTART: begin
					if (cell_v == 0) begin
						for (j = int'(pc_q) + 1; j < lim && !found; j++) begin
							if (prog_mem[j].opcode == bfie_pkg::OPC_JSTART) nest++;
							else if (prog_mem[j].opcode == bfie_pkg::OPC_JBACK) nest--;
							if (nest == 0) begin
								found = 1'b1;
								tgt = j;
							end
						end
						if (found) pc_q = tgt[11:0];
						else begin
							fault_q = 1'b1;
							run_q = 1'b0;
						end
					end else begin
						pc_q++;
					end
				end
				bfie_pkg::OPC_JBACK: begin
					if (cell_v != 0) begin
						if (pc_q >= 1 && int'(pc_q) - 1 < lim) begin
							for (j = int'(pc_q) - 1; j >= 0 && !found; j--) begin
								if (prog_mem[j].opcode == bfie_pkg::OPC_JBACK) nest++;
								else if (prog_mem[j].opcode == bfie_pkg::OPC_JSTART) nest--;
								if (nest == 0) begin
									found = 1'b1;
									tgt = j;
								end
							end
						end
						if (found) pc_q = tgt[11:0];
						else begin
							fault_q = 1'b1;
							run_q = 1'b0;
						end
					end else begin
						pc_q++;
					end
				end
				bfie_pkg::OPC_IN: begin
					tape_mem[ptr_q] = it.in_present ? it.in_byte : 8'd0;
					r.input_used = 1'b1;
					pc_q++;
				end
				bfie_pkg::OPC_OUT: begin
					r.out_valid = 1'b1;
					r.out_byte = cell_v;
					pc_q++;
				end
				bfie_pkg::OPC_ADD: begin
					tape_mem[ptr_q] = cell_v + w.arg[7:0];
					pc_q++;
				end
				bfie_pkg::OPC_MOVE: begin
					ptr_q = ptr_q + w.arg[11:0];
					pc_q++;
				end
				bfie_pkg::OPC_JUMP: begin
					if ($signed(w.arg) > 0)
						pc_q = (cell_v == 0) ? pc_q + w.arg[11:0] : pc_q + 12'd1;
					else
						pc_q = (cell_v != 0) ? pc_q + w.arg[11:0] : pc_q + 12'd1;
				end
				bfie_pkg::OPC_CLR: begin
					tape_mem[ptr_q] = 8'd0;
					pc_q++;
				end
				bfie_pkg::OPC_ADDCLR: begin
					t = ptr_q + w.arg[11:0];
					tape_mem[t] = tape_mem[t] + cell_v;
					tape_mem[ptr_q] = 8'd0;
					pc_q++;
				end
				bfie_pkg::OPC_MOVNZ: begin
					p = ptr_q;
					n = 0;
					while (tape_mem[p] != 0 && n < 4096) begin
						p = p + w.arg[11:0];
						n++;
					end
					if (tape_mem[p] == 0) begin
						ptr_q = p;
						pc_q++;
					end else begin
						fault_q = 1'b1;
						run_q = 1'b0;
					end
				end
				bfie_pkg::OPC_END: run_q = 1'b0;
				default: ;
			endcase
		end
		r.next_pc = pc_q;
		r.is_running = run_q;
		r.fault = fault_q;
	endtask

	always @(posedge clk or negedge arst_n) begin
		bfie_pkg::result_t r;
		if (!arst_n) begin
			for (int i = 0; i < 4096; i++) tape_mem[i] = 8'd0;
			pc_q = '0;
			ptr_q = '0;
			run_q = 1'b1;
			fault_q = 1'b0;
			prog_len = '0;
			expected_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) prog_len = cfg_data;
			if (item_valid && item_ready) begin
				step_executor(item, r);
				expected_q.push_back(r);
			end
			if (result_valid && result_ready) begin
				if (expected_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result transfer: pc=%0d", result.next_pc);
				end else begin
					r = expected_q.pop_front();
					if (result.out_valid !== r.out_valid || result.out_byte !== r.out_byte ||
					    result.input_used !== r.input_used || result.next_pc !== r.next_pc ||
					    result.is_running !== r.is_running || result.fault !== r.fault) begin
						errors++;
						if (errors <= 10)
							$display({"mismatch: exp out=%0b/%0d in=%0b pc=%0d run=%0b flt=%0b,",
								" got out=%0b/%0d in=%0b pc=%0d run=%0b flt=%0b"},
								r.out_valid, r.out_byte, r.input_used, r.next_pc,
								r.is_running, r.fault, result.out_valid, result.out_byte,
								result.input_used, result.next_pc, result.is_running,
								result.fault);
					end
				end
			end
			pending = expected_q.size();
		end
	end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the instruction executor: loads bracket-balanced
// random programs, steps through them with random input bytes under varying
// channel back-pressure, and ends with a stop by END or by a failed scan.
// ----------------------------------------------------------------------------
module tb_top;

	localparam logic [bfie_pkg::OPC_W-1:0] OPC_UNUSED = 4'd15;
	localparam int IDLE_LIMIT = 200000;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [bfie_pkg::LEN_W-1:0] cfg_data;
	logic                       item_valid;
	logic                       item_ready;
	bfie_pkg::item_t            item;
	logic                       result_valid;
	logic                       result_ready;
	bfie_pkg::result_t          result;
	int                         errors;
	int                         pending;

	int                         send_idle;
	int                         recv_idle;
	int                         idle_cycles;
	bfie_pkg::prog_word_t       shadow [4096];
	bit                         loaded [4096];
	int                         region_len;
	logic [11:0]                cur_pc;

	brainfuck_instruction_executor_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	bfie_checker i_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.errors       (errors),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) result_ready <= ($urandom_range(99) >= recv_idle);

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
			cur_pc <= '0;
		end else begin
			if (result_valid && result_ready) cur_pc <= result.next_pc;
			if ((item_valid && item_ready) || (result_valid && result_ready) ||
			    (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	function automatic bfie_pkg::prog_word_t random_word();
		bfie_pkg::prog_word_t w;
		w.arg = 16'($urandom);
		case ($urandom_range(11))
			0: w.opcode = bfie_pkg::OPC_INC;
			1: w.opcode = bfie_pkg::OPC_DEC;
			2: w.opcode = bfie_pkg::OPC_NEXT;
			3: w.opcode = bfie_pkg::OPC_PREV;
			4: w.opcode = bfie_pkg::OPC_IN;
			5: w.opcode = bfie_pkg::OPC_OUT;
			6: w.opcode = bfie_pkg::OPC_ADD;
			7: w.opcode = bfie_pkg::OPC_MOVE;
			8: begin
				w.opcode = bfie_pkg::OPC_JUMP;
				if ($urandom_range(3) != 0) begin
					w.arg = 16'($urandom_range(8, 1));
					if ($urandom_range(1)) w.arg = -w.arg;
				end else if (w.arg == 0) begin
					w.arg = 16'h8000;
				end
			end
			9: w.opcode = bfie_pkg::OPC_CLR;
			10: w.opcode = bfie_pkg::OPC_ADDCLR;
			default: begin
				w.opcode = bfie_pkg::OPC_MOVNZ;
				w.arg[0] = 1'b1;
			end
		endcase
		return w;
	endfunction

	function automatic bit runnable(input logic [11:0] a);
		bfie_pkg::prog_word_t w;
		w = shadow[a];
		if (!loaded[a] || w.opcode == bfie_pkg::OPC_END || w.opcode == OPC_UNUSED)
			return 1'b0;
		if ((w.opcode == bfie_pkg::OPC_JSTART || w.opcode == bfie_pkg::OPC_JBACK) &&
		    int'(a) >= region_len)
			return 1'b0;
		if (w.opcode == bfie_pkg::OPC_MOVNZ && !w.arg[0]) return 1'b0;
		return 1'b1;
	endfunction

	task automatic send(input bfie_pkg::item_t x);
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= x;
		do @(posedge clk); while (!item_ready);
	endtask

	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic load_word(input logic [11:0] a, input bfie_pkg::prog_word_t w);
		bfie_pkg::item_t x;
		x = bfie_pkg::item_t'({$urandom, $urandom});
		x.op = bfie_pkg::ITEM_LOAD;
		x.prog_addr = a;
		x.prog_opcode = w.opcode;
		x.prog_arg = w.arg;
		shadow[a] = w;
		loaded[a] = 1'b1;
		send(x);
	endtask

	task automatic execute(input bit raw);
		bfie_pkg::item_t x;
		if (!raw && !runnable(cur_pc)) load_word(cur_pc, random_word());
		x = bfie_pkg::item_t'({$urandom, $urandom});
		x.op = ~bfie_pkg::ITEM_LOAD;
		send(x);
		drain();
	endtask

	task automatic write_length(input int len);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= len[bfie_pkg::LEN_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		region_len = len;
	endtask

	// brackets stay balanced over the whole region so no scan can fail
	task automatic load_program(input int len);
		bfie_pkg::prog_word_t w;
		int nest;
		int left;
		bit clear_next;
		nest = 0;
		clear_next = 1'b0;
		for (int i = 0; i < len; i++) begin
			left = len - i;
			w = random_word();
			if (clear_next) begin
				w.opcode = bfie_pkg::OPC_CLR;
				clear_next = 1'b0;
			end else if (nest > 0 && (left == nest || $urandom_range(5) == 0)) begin
				w.opcode = bfie_pkg::OPC_JBACK;
				nest--;
			end else if (left > nest + 2 && $urandom_range(7) == 0) begin
				w.opcode = bfie_pkg::OPC_JSTART;
				nest++;
				clear_next = 1'b1;
			end
			load_word(i[11:0], w);
		end
		write_length(len);
	endtask

	task automatic run_phase(input int len, input int steps);
		bfie_pkg::prog_word_t w;
		load_program(len);
		for (int i = 0; i < steps; i++) begin
			if (len < 4096 && $urandom_range(9) == 0) begin
				w = bfie_pkg::prog_word_t'($urandom);
				load_word(12'($urandom_range(4095, len)), w);
			end else begin
				execute(1'b0);
			end
		end
	endtask

	initial begin
		bfie_pkg::prog_word_t w;
		bfie_pkg::prog_word_t stop_w;
		int k;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		item_valid = 1'b0;
		item = '0;
		region_len = 0;
		send_idle = 13;
		recv_idle = 53;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: one pass over every operation but JUMP, CLR and END, and its edge arguments
		load_word(12'd0, bfie_pkg::prog_word_t'{bfie_pkg::OPC_INC, 16'd0});
		load_word(12'd1, bfie_pkg::prog_word_t'{bfie_pkg::OPC_DEC, 16'd0});
		load_word(12'd2, bfie_pkg::prog_word_t'{bfie_pkg::OPC_JSTART, 16'd0});
		load_word(12'd3, bfie_pkg::prog_word_t'{bfie_pkg::OPC_OUT, 16'd0});
		load_word(12'd4, bfie_pkg::prog_word_t'{bfie_pkg::OPC_JBACK, 16'd0});
		load_word(12'd5, bfie_pkg::prog_word_t'{bfie_pkg::OPC_IN, 16'd0});
		load_word(12'd6, bfie_pkg::prog_word_t'{bfie_pkg::OPC_ADD, 16'h8000});
		load_word(12'd7, bfie_pkg::prog_word_t'{bfie_pkg::OPC_ADD, 16'h7fff});
		load_word(12'd8, bfie_pkg::prog_word_t'{bfie_pkg::OPC_OUT, 16'd0});
		load_word(12'd9, bfie_pkg::prog_word_t'{bfie_pkg::OPC_PREV, 16'd0});
		load_word(12'd10, bfie_pkg::prog_word_t'{bfie_pkg::OPC_NEXT, 16'd0});
		load_word(12'd11, bfie_pkg::prog_word_t'{bfie_pkg::OPC_MOVE, 16'h8000});
		load_word(12'd12, bfie_pkg::prog_word_t'{bfie_pkg::OPC_ADDCLR, 16'd0});
		load_word(12'd13, bfie_pkg::prog_word_t'{bfie_pkg::OPC_DEC, 16'd0});
		load_word(12'd14, bfie_pkg::prog_word_t'{bfie_pkg::OPC_ADDCLR, 16'h7fff});
		load_word(12'd15, bfie_pkg::prog_word_t'{bfie_pkg::OPC_MOVNZ, 16'hffff});
		load_word(12'd16, bfie_pkg::prog_word_t'{OPC_UNUSED, 16'hffff});
		write_length(16);
		repeat (17) execute(1'b1);
		execute(1'b0);

		run_phase(1, 40);
		run_phase($urandom_range(64, 16), 100);
		run_phase(0, 40);
		send_idle = 53;
		recv_idle = 13;
		run_phase(128, 60);
		run_phase($urandom_range(40, 8), 90);
		send_idle = 0;
		recv_idle = 0;
		run_phase($urandom_range(64, 16), 90);

		// stop the block: END, or a scan that cannot succeed
		write_length(0);
		k = $urandom_range(3);
		case (k)
			0: stop_w = bfie_pkg::prog_word_t'{bfie_pkg::OPC_END, 16'd0};
			1: stop_w = bfie_pkg::prog_word_t'{bfie_pkg::OPC_JSTART, 16'd0};
			2: stop_w = bfie_pkg::prog_word_t'{bfie_pkg::OPC_JBACK, 16'd0};
			default: stop_w = bfie_pkg::prog_word_t'{bfie_pkg::OPC_MOVNZ, 16'h8000};
		endcase
		load_word(cur_pc, bfie_pkg::prog_word_t'{bfie_pkg::OPC_CLR, 16'd0});
		w = (k == 1) ? bfie_pkg::prog_word_t'{bfie_pkg::OPC_CLR, 16'd0} :
			bfie_pkg::prog_word_t'{bfie_pkg::OPC_INC, 16'd0};
		load_word(cur_pc + 12'd1, w);
		load_word(cur_pc + 12'd2, stop_w);
		repeat (8) execute(1'b1);

		drain();
		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
